FILE: design/box_quadratic_entry_solver_defines.svh
// Assertion macros shared by the solver modules.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef BOX_QUADRATIC_ENTRY_SOLVER_DEFINES_SVH
`define BOX_QUADRATIC_ENTRY_SOLVER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition in this cycle implies property in this cycle.
`define BQES_ASSERT_IMPL(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Condition in this cycle implies property in the next cycle.
`define BQES_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define BQES_ASSERT_IMPL(lbl, clk, rst, cond, prop)
`define BQES_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

FILE: design/bqes_pkg.sv
`timescale 1ns / 1ps
package bqes_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VALUE_W   = 32;
  localparam int SUM_W     = 48;
  localparam int SIGMA_W   = 31;
  localparam int WIDE_W    = 64;
  localparam int COEF_W    = 35;
  localparam int SCALE_W   = 34;
  localparam int MUL_A_W   = 63;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int NUM_W     = SCALE_W + FRAC_BITS;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh2000_0000_0000_0000;
  localparam logic signed [WIDE_W-1:0] VAL_MAX  = 64'sd2147483647;
  localparam logic signed [WIDE_W-1:0] VAL_MIN  = -64'sd2147483648;
  localparam logic signed [WIDE_W-1:0] SUM_MAX  = 64'sd140737488355327;
  localparam logic signed [WIDE_W-1:0] SUM_MIN  = -64'sd140737488355328;
  localparam logic [SIGMA_W-1:0]        SIGMA_RESET = 31'd65536;
  localparam logic signed [VALUE_W-1:0] ONE_Q = 32'sh0001_0000;
  localparam logic [FRAC_BITS-1:0]      RND_ADD = '1;

  typedef enum logic [1:0] {
    CMD_CORNER  = 2'd0,
    CMD_DIAG    = 2'd1,
    CMD_OFFDIAG = 2'd2
  } cmd_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] a;
    logic signed [VALUE_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WIDE_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                      start;
    logic signed [COEF_W-1:0]  c;
    logic [SCALE_W-1:0]        s;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] q;
  } div_rsp_t;

  // Saturate a wide value into the value range.
  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    if (v > VAL_MAX) return VAL_MAX[VALUE_W-1:0];
    if (v < VAL_MIN) return VAL_MIN[VALUE_W-1:0];
    return v[VALUE_W-1:0];
  endfunction

  function automatic logic val_ovf(input logic signed [WIDE_W-1:0] v);
    return (v > VAL_MAX) || (v < VAL_MIN);
  endfunction

endpackage

FILE: design/box_quadratic_entry_solver.sv
`timescale 1ns / 1ps
// Latency: a corner, complementary or unused item offers its result the cycle after it is taken.
// Multiplies and divides run on the shared units.
// A solve is one divide (when the penalty is nonzero) plus three to six multiplies;
// an item takes up to two solves and two bound products.
// One item at a time; reset clears the sum, the flag and sets sigma to 1.0.
`include "box_quadratic_entry_solver_defines.svh"
module box_quadratic_entry_solver import bqes_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [SIGMA_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic signed [VALUE_W-1:0] coef_lin,
  input  logic signed [VALUE_W-1:0] coef_diag,
  input  logic signed [VALUE_W-1:0] low_row,
  input  logic signed [VALUE_W-1:0] high_row,
  input  logic signed [VALUE_W-1:0] low_col,
  input  logic signed [VALUE_W-1:0] high_col,
  input  logic                      is_binary,
  input  logic                      is_complement,
  input  logic                      last_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] y_first,
  output logic signed [VALUE_W-1:0] y_second,
  output logic signed [SUM_W-1:0]   objective,
  output logic                      saturated,
  output logic                      last_out
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_BND_LO = 10'b0000000010,
    S_BND_HI = 10'b0000000100,
    S_SOLVE  = 10'b0000001000,
    S_DIV    = 10'b0000010000,
    S_OBJ1   = 10'b0000100000,
    S_OBJ2   = 10'b0001000000,
    S_OBJ3   = 10'b0010000000,
    S_ADD    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    SEL_LO = 2'd0,
    SEL_HI = 2'd1,
    SEL_X  = 2'd2
  } sel_t;

  state_t                    state;
  sel_t                      obj_sel;
  logic [SIGMA_W-1:0]        sigma;
  logic signed [SUM_W-1:0]   sum;
  logic                      flag;
  logic signed [COEF_W-1:0]  c;
  logic signed [VALUE_W-1:0] c_diag;
  logic [SCALE_W-1:0]        s;
  logic signed [VALUE_W-1:0] lo, hi, x;
  logic signed [VALUE_W-1:0] row_lo, row_hi, col_lo, col_hi;
  logic                      dbl, second, pass2, bin_diag, waiting;
  logic signed [WIDE_W-1:0]  t1, obj_lo, term;
  logic signed [VALUE_W-1:0] y1, y2;
  logic                      last;

  mul_req_t                  mul_req;
  mul_rsp_t                  mul_rsp;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic signed [VALUE_W-1:0] ox;
  logic signed [WIDE_W-1:0]  osum, obj_val, q_ext, vert, tw, acc;
  logic signed [VALUE_W-1:0] vert_sat;
  logic                      in_box;
  logic                      bin_take;

  bqes_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  bqes_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign y_first   = y1;
  assign y_second  = y2;
  assign objective = sum;
  assign saturated = flag;
  assign last_out  = last;

  // A binary diagonal item folds both parts into one solve at three times the penalty.
  assign bin_take = (cmd == CMD_DIAG) && is_binary;

  // Point at which the objective is evaluated.
  always_comb begin
    case (obj_sel)
      SEL_LO:  ox = lo;
      SEL_HI:  ox = hi;
      default: ox = x;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = WIDE_W'(c);
    mul_req.b     = ox;
    case (state)
      S_BND_LO: begin
        mul_req.start = !waiting;
        mul_req.a     = WIDE_W'(row_lo);
        mul_req.b     = col_lo;
      end
      S_BND_HI: begin
        mul_req.start = !waiting;
        mul_req.a     = WIDE_W'(row_hi);
        mul_req.b     = col_hi;
      end
      S_OBJ1: mul_req.start = !waiting;
      S_OBJ2: begin
        mul_req.start = !waiting;
        mul_req.a     = signed'(WIDE_W'(s));
      end
      S_OBJ3: begin
        mul_req.start = !waiting;
        mul_req.a     = mul_rsp.res;
      end
      default: mul_req.start = 1'b0;
    endcase
  end

  assign div_req.start = (state == S_DIV) && !waiting;
  assign div_req.c     = c;
  assign div_req.s     = s;

  // Objective of the current point, vertex and its box test.
  assign osum     = t1 + (mul_rsp.res >>> 1);
  assign obj_val  = (osum > WIDE_LIM) ? WIDE_LIM : ((osum < -WIDE_LIM) ? -WIDE_LIM : osum);
  assign q_ext    = signed'(WIDE_W'(div_rsp.q));
  assign vert     = (!c[COEF_W-1] && (c != '0)) ? -q_ext : q_ext;
  assign vert_sat = sat_val(vert);
  assign in_box   = (lo <= vert_sat) && (vert_sat <= hi);

  // Weighted saturating accumulation.
  assign tw  = dbl ? (term <<< 1) : term;
  assign acc = WIDE_W'(sum) + tw;

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      sigma   <= SIGMA_RESET;
      sum     <= '0;
      flag    <= 1'b0;
      waiting <= 1'b0;
    end else begin
      if (cfg_write) sigma <= cfg_data;
      if (mul_req.start || div_req.start) waiting <= 1'b1;
      else if (mul_rsp.done || div_rsp.done) waiting <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last     <= last_in;
            y1       <= (cmd == CMD_CORNER) ? ONE_Q : '0;
            y2       <= '0;
            c        <= bin_take ? (COEF_W'(coef_lin) <<< 1) + COEF_W'(coef_diag)
                                 : COEF_W'(coef_lin);
            c_diag   <= coef_diag;
            s        <= bin_take ? SCALE_W'({sigma, 1'b0}) + SCALE_W'(sigma)
                                 : SCALE_W'(sigma);
            lo       <= low_row;
            hi       <= high_row;
            row_lo   <= low_row;
            row_hi   <= high_row;
            // Off-diagonal items use the column bounds; diagonal items square the row.
            col_lo   <= (cmd == CMD_OFFDIAG) ? low_col : low_row;
            col_hi   <= (cmd == CMD_OFFDIAG) ? high_col : high_row;
            pass2    <= 1'b0;
            second   <= (cmd == CMD_DIAG) && !is_binary;
            dbl      <= !bin_take;
            bin_diag <= bin_take;
            case (cmd)
              CMD_CORNER: begin
                flag  <= 1'b0;
                sum   <= SUM_W'(coef_lin) + SUM_W'(sigma >> 1);
                state <= S_OUT;
              end
              CMD_DIAG: state <= S_SOLVE;
              CMD_OFFDIAG: state <= is_complement ? S_OUT : S_BND_LO;
              default: state <= S_OUT;
            endcase
          end
        end
        S_BND_LO: begin
          if (mul_rsp.done) begin
            lo    <= sat_val(mul_rsp.res);
            flag  <= flag | val_ovf(mul_rsp.res);
            state <= S_BND_HI;
          end
        end
        S_BND_HI: begin
          if (mul_rsp.done) begin
            hi    <= sat_val(mul_rsp.res);
            flag  <= flag | val_ovf(mul_rsp.res);
            state <= S_SOLVE;
          end
        end
        S_SOLVE: begin
          obj_sel <= SEL_LO;
          state   <= (s != '0) ? S_DIV : S_OBJ1;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            x       <= vert_sat;
            flag    <= flag | val_ovf(vert);
            obj_sel <= in_box ? SEL_X : SEL_LO;
            state   <= S_OBJ1;
          end
        end
        S_OBJ1: begin
          if (mul_rsp.done) begin
            t1    <= mul_rsp.res;
            state <= S_OBJ2;
          end
        end
        S_OBJ2: begin
          if (mul_rsp.done) state <= S_OBJ3;
        end
        S_OBJ3: begin
          if (mul_rsp.done) begin
            case (obj_sel)
              SEL_LO: begin
                obj_lo  <= obj_val;
                obj_sel <= SEL_HI;
                state   <= S_OBJ1;
              end
              SEL_HI: begin
                // On a tie the upper bound wins.
                if (obj_lo < obj_val) begin
                  x    <= lo;
                  term <= obj_lo;
                end else begin
                  x    <= hi;
                  term <= obj_val;
                end
                state <= S_ADD;
              end
              default: begin
                term  <= obj_val;
                state <= S_ADD;
              end
            endcase
          end
        end
        S_ADD: begin
          if (acc > SUM_MAX) begin
            sum  <= SUM_MAX[SUM_W-1:0];
            flag <= 1'b1;
          end else if (acc < SUM_MIN) begin
            sum  <= SUM_MIN[SUM_W-1:0];
            flag <= 1'b1;
          end else begin
            sum <= acc[SUM_W-1:0];
          end
          if (pass2) begin
            y2    <= x;
            state <= S_OUT;
          end else begin
            y1 <= x;
            if (bin_diag) y2 <= x;
            if (second) begin
              // Second diagonal solve over the squared bounds.
              second <= 1'b0;
              pass2  <= 1'b1;
              dbl    <= 1'b0;
              c      <= COEF_W'(c_diag);
              state  <= S_BND_LO;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BQES_ASSERT_NEXT(a_take_busy, clk, rst, in_valid && !in_stall, in_stall)
  `BQES_ASSERT_IMPL(a_out_blocks_in, clk, rst, out_valid, in_stall)
  `BQES_ASSERT_IMPL(a_one_unit, clk, rst, mul_req.start, !div_req.start)

endmodule

FILE: design/bqes_mul.sv
`timescale 1ns / 1ps
`include "box_quadratic_entry_solver_defines.svh"
module bqes_mul import bqes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic [PROD_W-1:0]    mcand;
  logic [MUL_B_W-1:0]   mplier;
  logic [PROD_W-1:0]    prod;
  logic                 neg;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 fin;
  logic [WIDE_W-1:0]    a_abs;
  logic [MUL_B_W-1:0]   b_abs;
  logic [PROD_W:0]      rnd;
  logic [PROD_W-FRAC_BITS:0] mag_full;
  logic signed [WIDE_W-1:0]  mag;

  // Operand magnitudes; the sign is applied after the floor step.
  assign a_abs = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
  assign b_abs = req.b[VALUE_W-1] ? MUL_B_W'(-req.b) : MUL_B_W'(req.b);

  // Floor division by the fraction scale and clamp of the magnitude.
  assign rnd      = {1'b0, prod} + (neg ? (PROD_W+1)'(RND_ADD) : '0);
  assign mag_full = rnd[PROD_W:FRAC_BITS];
  assign mag      = (mag_full > (PROD_W-FRAC_BITS+1)'(WIDE_LIM)) ? WIDE_LIM
                                                                 : signed'(mag_full[WIDE_W-1:0]);

  // Shift-add loop, one multiplier bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && !busy && fin;
      if (req.start) begin
        mcand  <= {{MUL_B_W{1'b0}}, a_abs[MUL_A_W-1:0]};
        mplier <= b_abs;
        prod   <= '0;
        neg    <= req.a[WIDE_W-1] ^ req.b[VALUE_W-1];
        cnt    <= '0;
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin     <= 1'b0;
        rsp.res <= neg ? -mag : mag;
      end
    end
  end

  `BQES_ASSERT_IMPL(a_mul_idle_start, clk, rst, req.start, !busy && !fin)
  `BQES_ASSERT_NEXT(a_mul_done_pulse, clk, rst, rsp.done, !rsp.done)

endmodule

FILE: design/bqes_div.sv
`timescale 1ns / 1ps
module bqes_div import bqes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [NUM_W-1:0]     num;
  logic [SCALE_W-1:0]   den;
  logic [SCALE_W-1:0]   rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic [SCALE_W-1:0]   c_abs;
  logic [SCALE_W:0]     rem_sh;
  logic                 ge;

  assign c_abs  = req.c[COEF_W-1] ? SCALE_W'(-req.c) : SCALE_W'(req.c);
  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= !req.start && busy && (cnt == DIV_CNT_W'(NUM_W - 1));
      if (req.start) begin
        num   <= {c_abs, {FRAC_BITS{1'b0}}};
        den   <= req.s;
        rem   <= '0;
        rsp.q <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        rem   <= ge ? SCALE_W'(rem_sh - {1'b0, den}) : rem_sh[SCALE_W-1:0];
        rsp.q <= {rsp.q[NUM_W-2:0], ge};
        num   <= num << 1;
        cnt   <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) busy <= 1'b0;
      end
    end
  end

endmodule

FILE: bench/box_quadratic_entry_solver_checker.sv
`timescale 1ns / 1ps
module box_quadratic_entry_solver_checker import bqes_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [SIGMA_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                cmd,
  input  logic signed [VALUE_W-1:0] coef_lin,
  input  logic signed [VALUE_W-1:0] coef_diag,
  input  logic signed [VALUE_W-1:0] low_row,
  input  logic signed [VALUE_W-1:0] high_row,
  input  logic signed [VALUE_W-1:0] low_col,
  input  logic signed [VALUE_W-1:0] high_col,
  input  logic                      is_binary,
  input  logic                      is_complement,
  input  logic                      last_in,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] y_first,
  input  logic signed [VALUE_W-1:0] y_second,
  input  logic signed [SUM_W-1:0]   objective,
  input  logic                      saturated,
  input  logic                      last_out,
  output int                        errors,
  output int                        pending,
  output int                        results_seen
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] y1;
    logic signed [VALUE_W-1:0] y2;
    logic signed [SUM_W-1:0]   obj;
    logic                      sat;
    logic                      last;
  } solution_t;

  localparam longint LIM61 = 64'sd1 <<< 61;

  solution_t solutions_due[$];
  longint    run_sum;
  logic      run_sat;
  longint    penalty;

  // Signed fixed-point product, floored, clamped to the wide range.
  function automatic longint fx_mul(longint a, longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = (pa * pb) >>> FRAC_BITS;
    if (p > LIM61) return LIM61;
    if (p < -LIM61) return -LIM61;
    return longint'(p[63:0]);
  endfunction

  // Saturate into the value range; the flag remembers any clipping.
  function automatic longint clip_value(longint v);
    if (v > 64'sd2147483647) begin
      run_sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      run_sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint cost_at(longint c, longint s, longint x);
    longint lin, quad, tot;
    lin = fx_mul(c, x);
    quad = fx_mul(fx_mul(s, x), x) >>> 1;
    tot = lin + quad;
    if (tot > LIM61) return LIM61;
    if (tot < -LIM61) return -LIM61;
    return tot;
  endfunction

  // Unconstrained minimizer -c/s, truncated toward zero.
  function automatic longint stationary_point(longint c, longint s);
    logic [127:0] num, q;
    longint mag;
    num = (c < 0) ? -c : c;
    num = num << FRAC_BITS;
    q = num / s;
    if (q > LIM61) q = LIM61;
    mag = longint'(q[63:0]);
    return clip_value((c > 0) ? -mag : mag);
  endfunction

  function automatic longint box_minimize(longint c, longint s, longint lo, longint hi,
                                          output longint cost);
    longint x;
    logic in_box;
    x = 0;
    in_box = 1'b0;
    if (s > 0) begin
      x = stationary_point(c, s);
      in_box = (lo <= x) && (x <= hi);
    end
    if (!in_box) x = (cost_at(c, s, lo) < cost_at(c, s, hi)) ? lo : hi;
    cost = cost_at(c, s, x);
    return x;
  endfunction

  function automatic void accumulate(longint t);
    longint top, bot;
    top = (64'sd1 <<< (SUM_W - 1)) - 1;
    bot = -top - 1;
    if (t > 0 && run_sum > top - t) begin
      run_sum = top;
      run_sat = 1'b1;
    end else if (t < 0 && run_sum < bot - t) begin
      run_sum = bot;
      run_sat = 1'b1;
    end else begin
      run_sum = run_sum + t;
    end
  endfunction

  function automatic solution_t solve_entry();
    solution_t r;
    longint cl, cd, lr, hr, lc, hc, y1, y2, t;
    cl = coef_lin;
    cd = coef_diag;
    lr = low_row;
    hr = high_row;
    lc = low_col;
    hc = high_col;
    y1 = 0;
    y2 = 0;
    case (cmd)
      CMD_CORNER: begin
        y1 = longint'(ONE_Q);
        run_sat = 1'b0;
        run_sum = 0;
        accumulate(cl + (penalty >>> 1));
      end
      CMD_DIAG: begin
        if (is_binary) begin
          y1 = box_minimize(2 * cl + cd, 3 * penalty, lr, hr, t);
          y2 = y1;
          accumulate(t);
        end else begin
          y1 = box_minimize(cl, penalty, lr, hr, t);
          accumulate(2 * t);
          y2 = box_minimize(cd, penalty, clip_value(fx_mul(lr, lr)),
                            clip_value(fx_mul(hr, hr)), t);
          accumulate(t);
        end
      end
      CMD_OFFDIAG: begin
        if (!is_complement) begin
          y1 = box_minimize(cl, penalty, clip_value(fx_mul(lr, lc)),
                            clip_value(fx_mul(hr, hc)), t);
          accumulate(2 * t);
        end
      end
      default: ;
    endcase
    r.y1 = y1[VALUE_W-1:0];
    r.y2 = y2[VALUE_W-1:0];
    r.obj = run_sum[SUM_W-1:0];
    r.sat = run_sat;
    r.last = last_in;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    errors++;
    if (errors <= 20)
      $display("%0t: result %0d field %s is %0d, predicted %0d",
               $time, results_seen, field, got, want);
  endtask

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    run_sum = 0;
    run_sat = 1'b0;
    penalty = SIGMA_RESET;
  end

  // Track the register, predict each accepted item and check each result.
  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      run_sum = 0;
      run_sat = 1'b0;
      penalty = SIGMA_RESET;
      solutions_due.delete();
    end else begin
      if (cfg_write) penalty = cfg_data;
      if (out_valid && !out_stall) begin
        if (solutions_due.size() == 0) begin
          report("unexpected", 1, 0);
        end else begin
          want = solutions_due.pop_front();
          if (y_first !== want.y1) report("y_first", y_first, want.y1);
          if (y_second !== want.y2) report("y_second", y_second, want.y2);
          if (objective !== want.obj) report("objective", objective, want.obj);
          if (saturated !== want.sat) report("saturated", saturated, want.sat);
          if (last_out !== want.last) report("last_out", last_out, want.last);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) solutions_due.push_back(solve_entry());
    end
    pending = solutions_due.size();
  end

endmodule

FILE: bench/box_quadratic_entry_solver_test.sv
`timescale 1ns / 1ps
module box_quadratic_entry_solver_test;
  import bqes_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 700;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [SIGMA_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                cmd = CMD_CORNER;
  logic signed [VALUE_W-1:0] coef_lin = '0;
  logic signed [VALUE_W-1:0] coef_diag = '0;
  logic signed [VALUE_W-1:0] low_row = '0;
  logic signed [VALUE_W-1:0] high_row = '0;
  logic signed [VALUE_W-1:0] low_col = '0;
  logic signed [VALUE_W-1:0] high_col = '0;
  logic                      is_binary = 1'b0;
  logic                      is_complement = 1'b0;
  logic                      last_in = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] y_first;
  logic signed [VALUE_W-1:0] y_second;
  logic signed [SUM_W-1:0]   objective;
  logic                      saturated;
  logic                      last_out;

  int errors, pending, results_seen;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int items_sent = 0;

  always #4 clk = ~clk;

  box_quadratic_entry_solver dut (.*);

  box_quadratic_entry_solver_checker checker_inst (.*);

  // Result side: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one item and wait until it is taken; optional idle gap after it.
  task automatic send_entry(logic [1:0] k, logic signed [31:0] cl, logic signed [31:0] cd,
                            logic signed [31:0] lr, logic signed [31:0] hr,
                            logic signed [31:0] lc, logic signed [31:0] hc,
                            logic bin, logic comp, logic lst);
    logic stalled;
    in_valid <= 1'b1;
    cmd <= k;
    coef_lin <= cl;
    coef_diag <= cd;
    low_row <= lr;
    high_row <= hr;
    low_col <= lc;
    high_col <= hc;
    is_binary <= bin;
    is_complement <= comp;
    last_in <= lst;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has left the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_penalty(logic [SIGMA_W-1:0] value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly modest Q16.16 values so the minimizer lands inside the box.
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  task automatic send_random(logic [1:0] k, logic lst);
    logic signed [31:0] lr, hr, lc, hc, tmp;
    lr = pick_value();
    hr = lr + $signed($urandom_range(0, 32'h0008_0000));
    if ($urandom_range(9) == 0) begin
      tmp = lr;
      lr = hr;
      hr = tmp;
    end
    lc = pick_value();
    hc = lc + $signed($urandom_range(0, 32'h0008_0000));
    send_entry(k, pick_value(), pick_value(), lr, hr, lc, hc,
               1'($urandom_range(1)), 1'($urandom_range(1)), lst);
  endtask

  // One matrix: corner, then diagonal and off-diagonal entries.
  task automatic send_matrix();
    int n;
    n = $urandom_range(1, 4);
    send_random(CMD_CORNER, 1'b0);
    for (int i = 0; i < n; i++) begin
      send_random($urandom_range(19) == 0 ? CMD_UNUSED : CMD_DIAG, 1'b0);
      for (int j = 0; j < i; j++)
        send_random(CMD_OFFDIAG, (i == n - 1) && (j == i - 1));
    end
    if (n == 1) send_random(CMD_DIAG, 1'b1);
  endtask

  initial begin
    logic [SIGMA_W-1:0] penalties [6];
    penalties = '{31'd65536, 31'd0, 31'd1, 31'h7fff_ffff, 31'd0, 31'd196608};
    penalties[4] = SIGMA_W'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed entries: field extremes, every kind, saturation and odd boxes.
    set_penalty(31'd65536);
    send_entry(CMD_CORNER, 32'sh7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0);
    send_entry(CMD_CORNER, 32'sh8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
    send_entry(CMD_DIAG, 32'sh0001_0000, 32'sh0002_0000, -32'sh0004_0000, 32'sh0004_0000,
               0, 0, 1, 0, 0);
    send_entry(CMD_DIAG, -32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000,
               0, 0, 0, 0, 0);
    send_entry(CMD_DIAG, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
               0, 0, 0, 0, 0);
    send_entry(CMD_DIAG, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
               0, 0, 1, 0, 0);
    send_entry(CMD_OFFDIAG, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0003_0000,
               32'sh0002_0000, 32'sh0004_0000, 0, 0, 0);
    send_entry(CMD_OFFDIAG, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0003_0000,
               32'sh0002_0000, 32'sh0004_0000, 0, 1, 0);
    send_entry(CMD_OFFDIAG, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0);
    send_entry(CMD_DIAG, 32'sh0001_0000, 32'sh0001_0000, 32'sh0005_0000, -32'sh0005_0000,
               0, 0, 0, 0, 0);
    send_entry(CMD_UNUSED, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 32'sh0001_0000,
               0, 0, 1, 1, 1);
    // Repeated huge costs drive the running sum into saturation.
    for (int i = 0; i < 6; i++)
      send_entry(CMD_OFFDIAG, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh7fff_ffff, 0, 0, i == 5);
    set_penalty(31'd1);
    send_entry(CMD_DIAG, 32'sh7fff_ffff, 32'sh8000_0000, -32'sh0001_0000, 32'sh0001_0000,
               0, 0, 1, 0, 1);

    // Random matrices under each penalty and handshake pattern.
    for (int p = 0; p < 6; p++) begin
      set_penalty(penalties[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (p == 2) hold_request = 400;
      while (items_sent < 25 + (p + 1) * 165) begin
        send_matrix();
        if ($urandom_range(30) == 0) wait_idle();
      end
    end

    wait_idle();
    $display("Covered %0d entries (%0d results) under six penalty settings,", items_sent,
             results_seen);
    $display("with idle gaps, stalls, a long result hold-off and saturation cases.");
    if (errors == 0)
      $display("box_quadratic_entry_solver: match");
    else
      $display("box_quadratic_entry_solver: mismatch");
    $finish;
  end

  initial begin
    #80ms;
    $display("box_quadratic_entry_solver: mismatch");
    $finish;
  end

endmodule
